[rtl/core/sbpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbpd_pkg;

   // boundary tables as given; the band count parameters may use fewer entries
   localparam int NARROW_TABLE = 75;
   localparam int WIDE_TABLE   = 19;

   localparam int LEVEL_W = 12;               // 4 integer + 8 fraction bits
   localparam int WORD_W  = 2 * LEVEL_W;      // {bar, peak} per memory word
   localparam int CSR_W   = 10;

   typedef enum logic [1:0] {
      CSR_LONG_BAND_MODE  = 2'd0,
      CSR_SHOW_PEAK_MARKS = 2'd1,
      CSR_BAR_FALLOFF     = 2'd2,
      CSR_PEAK_FALLOFF    = 2'd3
   } csr_index_type;

   // band close event from the bin tracker
   typedef struct packed {
      logic       close;
      logic [6:0] band;
      logic [7:0] y;       // band maximum >> 7
      logic       last;
   } close_type;

   function automatic logic [7:0] narrow_edge(input logic [7:0] idx);
      logic [7:0] e;
      if (idx <= 8'd58) begin
         e = idx;
      end else begin
         case (idx)
            8'd59:   e = 8'd61;
            8'd60:   e = 8'd66;
            8'd61:   e = 8'd71;
            8'd62:   e = 8'd76;
            8'd63:   e = 8'd81;
            8'd64:   e = 8'd87;
            8'd65:   e = 8'd93;
            8'd66:   e = 8'd100;
            8'd67:   e = 8'd107;
            8'd68:   e = 8'd114;
            8'd69:   e = 8'd122;
            8'd70:   e = 8'd131;
            8'd71:   e = 8'd140;
            8'd72:   e = 8'd150;
            8'd73:   e = 8'd161;
            8'd74:   e = 8'd172;
            8'd75:   e = 8'd184;
            default: e = 8'd255;
         endcase
      end
      return e;
   endfunction

   function automatic logic [7:0] wide_edge(input logic [7:0] idx);
      logic [7:0] e;
      if (idx <= 8'd8) begin
         e = idx;
      end else begin
         case (idx)
            8'd9:    e = 8'd11;
            8'd10:   e = 8'd15;
            8'd11:   e = 8'd20;
            8'd12:   e = 8'd27;
            8'd13:   e = 8'd36;
            8'd14:   e = 8'd47;
            8'd15:   e = 8'd62;
            8'd16:   e = 8'd82;
            8'd17:   e = 8'd107;
            8'd18:   e = 8'd141;
            8'd19:   e = 8'd184;
            default: e = 8'd255;
         endcase
      end
      return e;
   endfunction

   // smallest y reaching level m+1; floor(ln(y) * 3.60673760222)
   localparam logic [7:0] LEVEL_THRESH [15] = '{
      8'd2, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10,
      8'd13, 8'd17, 8'd22, 8'd28, 8'd37, 8'd49, 8'd65
   };

   function automatic logic [3:0] level_of(input logic [7:0] y);
      logic [3:0] m;
      m = 4'd0;
      for (int k = 0; k < 15; k++) begin
         if (y >= LEVEL_THRESH[k]) m = 4'(k + 1);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[rtl/core/sbpd_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sbpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] bin_magnitude;
   logic               frame_start;

   modport source (output valid, output bin_magnitude, output frame_start, input ready);
   modport sink   (input valid, input bin_magnitude, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/core/sbpd_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sbpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  band_index;
   logic [11:0] bar_level;
   logic [11:0] peak_level;
   logic        last_band;

   modport source (output valid, output band_index, output bar_level, output peak_level,
                   output last_band, input ready);
   modport sink   (input valid, input band_index, input bar_level, input peak_level,
                   input last_band, output ready);
endinterface

`default_nettype wire

[rtl/core/spectrum_band_bar_peak_decay.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                          Moves on
// req_ch   in   bin_magnitude, frame_start                      valid && ready
// rsp_ch   out  band_index, bar_level, peak_level, last_band    valid && ready
// csr_*    in   csr_index, csr_wr_data                          csr_wr_en
//
// One bin per cycle sustained. A band close reads the bar/peak memory at accept,
// updates and writes back when the update stage advances, which also loads the
// result into the output register. A close on the entry being written forwards.
// Reset (synchronous) clears the counters and the valid bits of all store entries.
// A stalled output holds the update stage; req_ready drops only then.

module spectrum_band_bar_peak_decay #(
   parameter int NARROW_BANDS = 75,
   parameter int WIDE_BANDS   = 19,
   parameter int BIN_COUNT    = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   sbpd_req_if.sink                       req_ch,
   sbpd_rsp_if.source                     rsp_ch,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [sbpd_pkg::CSR_W-1:0] csr_wr_data
);

   localparam int NARROW_USED = (NARROW_BANDS < sbpd_pkg::NARROW_TABLE) ?
                                NARROW_BANDS : sbpd_pkg::NARROW_TABLE;
   localparam int WIDE_USED   = (WIDE_BANDS < sbpd_pkg::WIDE_TABLE) ?
                                WIDE_BANDS : sbpd_pkg::WIDE_TABLE;
   localparam int AW          = (NARROW_BANDS > 1) ? $clog2(NARROW_BANDS) : 1;
   localparam int LW          = sbpd_pkg::LEVEL_W;

   // configuration
   logic       long_band_mode_ff;
   logic       show_peak_marks_ff;
   logic [9:0] bar_falloff_ff;
   logic [7:0] peak_falloff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_band_mode_ff  <= 1'b0;
         show_peak_marks_ff <= 1'b1;
         bar_falloff_ff     <= 10'd563;
         peak_falloff_ff    <= 8'd51;
      end else if (csr_wr_en) begin
         unique case (sbpd_pkg::csr_index_type'(csr_index))
            sbpd_pkg::CSR_LONG_BAND_MODE:  long_band_mode_ff  <= csr_wr_data[0];
            sbpd_pkg::CSR_SHOW_PEAK_MARKS: show_peak_marks_ff <= csr_wr_data[0];
            sbpd_pkg::CSR_BAR_FALLOFF:     bar_falloff_ff     <= csr_wr_data[9:0];
            sbpd_pkg::CSR_PEAK_FALLOFF:    peak_falloff_ff    <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // bin tracking
   sbpd_pkg::close_type close_evt;
   logic                accept;

   sbpd_band_track #(
      .NARROW_BANDS (NARROW_BANDS),
      .NARROW_USED  (NARROW_USED),
      .WIDE_USED    (WIDE_USED),
      .BIN_COUNT    (BIN_COUNT)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .bin_magnitude  (req_ch.bin_magnitude),
      .frame_start    (req_ch.frame_start),
      .long_band_mode (long_band_mode_ff),
      .close_evt      (close_evt)
   );

   // update stage
   logic       s1_valid_ff, s1_valid_in;
   logic [6:0] s1_band_ff;
   logic [7:0] s1_y_ff;
   logic       s1_last_ff;
   logic       s1_adv;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [6:0]                  rsp_band_ff;
   logic [LW-1:0]               rsp_bar_ff, rsp_peak_ff;
   logic                        rsp_last_ff;

   logic [sbpd_pkg::WORD_W-1:0] rd_word, new_word;

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   sbpd_store #(
      .DEPTH (NARROW_BANDS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && close_evt.close),
      .rd_addr (close_evt.band[AW-1:0]),
      .wr_en   (s1_adv),
      .wr_addr (s1_band_ff[AW-1:0]),
      .wr_data (new_word),
      .rd_data (rd_word)
   );

   sbpd_update u_update (
      .y               (s1_y_ff),
      .old_word        (rd_word),
      .bar_falloff     (bar_falloff_ff),
      .peak_falloff    (peak_falloff_ff),
      .show_peak_marks (show_peak_marks_ff),
      .new_word        (new_word)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)      s1_valid_in = close_evt.close;
      else if (s1_adv) s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)            rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && close_evt.close) begin
         s1_band_ff <= close_evt.band;
         s1_y_ff    <= close_evt.y;
         s1_last_ff <= close_evt.last;
      end
      if (s1_adv) begin
         rsp_band_ff <= s1_band_ff;
         rsp_bar_ff  <= new_word[2*LW-1:LW];
         rsp_peak_ff <= new_word[LW-1:0];
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.band_index = rsp_band_ff;
   assign rsp_ch.bar_level  = rsp_bar_ff;
   assign rsp_ch.peak_level = rsp_peak_ff;
   assign rsp_ch.last_band  = rsp_last_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ch.ready)
      else $error("item taken while the update stage is stalled");

   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bar_ff <= 12'd3840) && (rsp_peak_ff <= 12'd3840))
      else $error("level above full scale");

endmodule

`default_nettype wire

[rtl/core/sbpd_band_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpd_band_track #(
   parameter int NARROW_BANDS = 75,
   parameter int NARROW_USED  = 75,
   parameter int WIDE_USED    = 19,
   parameter int BIN_COUNT    = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic signed [15:0] bin_magnitude,
   input  wire logic               frame_start,
   input  wire logic               long_band_mode,
   output sbpd_pkg::close_type     close_evt
);

   localparam int CNT_W = $clog2(BIN_COUNT + 1);

   logic [CNT_W-1:0] bin_count_ff, bin_count_in;
   logic [6:0]       band_pointer_ff, band_pointer_in;
   logic [14:0]      band_max_ff, band_max_in;

   logic [CNT_W-1:0] cnt;
   logic [6:0]       ptr;
   logic [14:0]      cur_max, new_max, mag;
   logic [7:0]       nbands, ptr_inc, band_end;
   logic             active, closing;

   always_comb begin
      cnt     = frame_start ? '0 : bin_count_ff;
      ptr     = frame_start ? '0 : band_pointer_ff;
      cur_max = frame_start ? '0 : band_max_ff;
      mag     = bin_magnitude[15] ? '0 : bin_magnitude[14:0];
      new_max = (mag > cur_max) ? mag : cur_max;
      nbands  = long_band_mode ? 8'(NARROW_USED) : 8'(WIDE_USED);
      ptr_inc = {1'b0, ptr} + 8'd1;
      active  = ({1'b0, ptr} < nbands) && ({1'b0, ptr} < 8'(NARROW_BANDS));
      band_end = long_band_mode ? sbpd_pkg::narrow_edge(ptr_inc)
                                : sbpd_pkg::wide_edge(ptr_inc);
      closing = active && (({1'b0, cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(band_end));

      bin_count_in    = bin_count_ff;
      band_pointer_in = band_pointer_ff;
      band_max_in     = band_max_ff;
      if (accept) begin
         bin_count_in    = (cnt < CNT_W'(BIN_COUNT)) ? cnt + CNT_W'(1) : cnt;
         band_pointer_in = closing ? ptr_inc[6:0] : ptr;
         band_max_in     = closing ? '0 : (active ? new_max : cur_max);
      end

      close_evt.close = closing;
      close_evt.band  = ptr;
      close_evt.y     = new_max[14:7];
      close_evt.last  = (ptr_inc == nbands);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff    <= '0;
         band_pointer_ff <= '0;
         band_max_ff     <= '0;
      end else begin
         bin_count_ff    <= bin_count_in;
         band_pointer_ff <= band_pointer_in;
         band_max_ff     <= band_max_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/sbpd_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpd_store #(
   parameter int DEPTH = 75,
   parameter int AW    = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [sbpd_pkg::WORD_W-1:0] wr_data,
   output logic [sbpd_pkg::WORD_W-1:0]      rd_data
);

   logic [sbpd_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [sbpd_pkg::WORD_W-1:0] rd_q_ff;
   logic [sbpd_pkg::WORD_W-1:0] fwd_data_ff;
   logic [DEPTH-1:0]            valid_ff;
   logic                        rd_valid_ff;
   logic                        fwd_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_q_ff     <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            // write to the same entry in the read cycle: memory returns the old word
            fwd_ff      <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (rd_valid_ff ? rd_q_ff : '0);

   a_forward_same_entry: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
      else $error("read after same-entry write lost the new word");

   a_read_data_holds: assert property (@(posedge clock) disable iff (reset)
      !rd_en && !$past(reset) |=> $stable(rd_data))
      else $error("read data changed without a read");

endmodule

`default_nettype wire

[rtl/core/sbpd_update.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpd_update (
   input  wire logic [7:0]                  y,
   input  wire logic [sbpd_pkg::WORD_W-1:0] old_word,
   input  wire logic [9:0]                  bar_falloff,
   input  wire logic [7:0]                  peak_falloff,
   input  wire logic                        show_peak_marks,
   output logic [sbpd_pkg::WORD_W-1:0]      new_word
);

   localparam int LW = sbpd_pkg::LEVEL_W;

   logic [LW-1:0] target, bar_old, peak_old, bar_dec, peak_dec, bar_new, peak_new;

   always_comb begin
      target   = {sbpd_pkg::level_of(y), 8'h00};
      bar_old  = old_word[2*LW-1:LW];
      peak_old = old_word[LW-1:0];

      bar_dec  = (bar_old > LW'(bar_falloff)) ? bar_old - LW'(bar_falloff) : '0;
      peak_dec = (peak_old > LW'(peak_falloff)) ? peak_old - LW'(peak_falloff) : '0;

      bar_new  = (bar_dec > target) ? bar_dec : target;
      peak_new = show_peak_marks ? ((peak_dec > target) ? peak_dec : target) : peak_old;

      new_word = {bar_new, peak_new};
   end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int NARROW_COUNT  = 75;
   localparam int WIDE_COUNT    = 19;
   localparam int FRAME_BINS    = 256;
   localparam int RANDOM_PHASES = 9;

   // band end bins above the one-bin-per-band region
   localparam int NARROW_UPPER [17] = '{61, 66, 71, 76, 81, 87, 93, 100, 107, 114, 122, 131,
                                        140, 150, 161, 172, 184};
   localparam int WIDE_UPPER [11] = '{11, 15, 20, 27, 36, 47, 62, 82, 107, 141, 184};
   // smallest shifted magnitude that reaches each next level
   localparam int LEVEL_STEPS [15] = '{2, 2, 3, 4, 5, 6, 7, 10, 13, 17, 22, 28, 37, 49, 65};

   typedef struct packed {
      logic [6:0]  band;
      logic [11:0] bar;
      logic [11:0] peak;
      logic        last;
   } band_report_type;

   typedef struct packed {
      logic signed [15:0] mag;
      logic               fs;
      logic               typed;    // expectation written below instead of predicted
      logic               emits;
      band_report_type    rep;
   } bin_row_type;

   // wide bands, reset settings; the first bands are one bin each
   localparam bin_row_type DIRECTED_BINS [16] = '{
      '{16'sh7FFF, 1'b1, 1'b1, 1'b1, '{7'd0, 12'd3840, 12'd3840, 1'b0}},
      '{16'sh8000, 1'b0, 1'b1, 1'b1, '{7'd1, 12'd0, 12'd0, 1'b0}},
      '{16'sd255,  1'b0, 1'b1, 1'b1, '{7'd2, 12'd0, 12'd0, 1'b0}},
      '{16'sd256,  1'b0, 1'b1, 1'b1, '{7'd3, 12'd512, 12'd512, 1'b0}},
      '{16'sd512,  1'b0, 1'b1, 1'b1, '{7'd4, 12'd1024, 12'd1024, 1'b0}},   // y=4 lands low
      '{16'sd2048, 1'b0, 1'b1, 1'b1, '{7'd5, 12'd2304, 12'd2304, 1'b0}},   // y=16 lands low
      '{16'sd8192, 1'b0, 1'b1, 1'b1, '{7'd6, 12'd3584, 12'd3584, 1'b0}},   // y=64 lands low
      '{16'sd8320, 1'b0, 1'b1, 1'b1, '{7'd7, 12'd3840, 12'd3840, 1'b0}},
      '{16'shFFFF, 1'b0, 1'b1, 1'b0, '0},
      '{16'sd640,  1'b0, 1'b1, 1'b0, '0},
      '{16'sd0,    1'b0, 1'b1, 1'b1, '{7'd8, 12'd1280, 12'd1280, 1'b0}},
      // second frame: band 0 decays from full scale
      '{16'sd0,    1'b1, 1'b1, 1'b1, '{7'd0, 12'd3277, 12'd3789, 1'b0}},
      '{16'sh7FFF, 1'b0, 1'b1, 1'b1, '{7'd1, 12'd3840, 12'd3840, 1'b0}},
      '{16'sh7F80, 1'b0, 1'b0, 1'b0, '0},
      '{16'sd100,  1'b0, 1'b0, 1'b0, '0},
      '{16'sd0,    1'b1, 1'b0, 1'b0, '0}
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   sbpd_pkg::csr_index_type         csr_index;
   logic [sbpd_pkg::CSR_W-1:0]      csr_wr_data;

   sbpd_req_if req_ch ();
   sbpd_rsp_if rsp_ch ();

   spectrum_band_bar_peak_decay u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // predictor copy of settings and state
   logic        long_mode;
   logic        peak_on;
   logic [9:0]  bar_fall;
   logic [7:0]  peak_fall;
   int unsigned bins_seen;
   int unsigned band_ptr;
   logic [14:0] band_hi;
   logic [11:0] bar_q  [NARROW_COUNT];
   logic [11:0] peak_q [NARROW_COUNT];

   band_report_type band_reports [$];
   band_report_type want;
   logic            calm;
   int unsigned     stall_left;
   int unsigned     mismatches;
   int unsigned     reports_checked;
   int unsigned     frame_closes;
   int unsigned     bins_sent;
   int unsigned     frames_started;
   int unsigned     settings_used;
   int unsigned     frame_pos;
   int unsigned     frame_len;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [11:0] decay_to(input logic [11:0] level, input logic [9:0] fall,
                                            input logic [11:0] floor_level);
      logic [11:0] d;
      d = (level > 12'(fall)) ? level - 12'(fall) : 12'd0;
      return (d > floor_level) ? d : floor_level;
   endfunction

   function automatic logic predict_band(input logic signed [15:0] mag, input logic fs,
                                         output band_report_type rep);
      logic [14:0] pos_mag;
      int unsigned nbands;
      int unsigned stop;
      int unsigned k;
      int unsigned lvl;
      logic [11:0] target;
      predict_band = 1'b0;
      rep = '0;
      pos_mag = mag[15] ? 15'd0 : mag[14:0];
      if (fs) begin
         bins_seen = 0;
         band_ptr  = 0;
         band_hi   = '0;
      end
      nbands = long_mode ? NARROW_COUNT : WIDE_COUNT;
      if (band_ptr < nbands) begin
         if (pos_mag > band_hi) band_hi = pos_mag;
         k = band_ptr + 1;
         if (long_mode) begin
            stop = (k <= 58) ? k : NARROW_UPPER[k - 59];
         end else begin
            stop = (k <= 8) ? k : WIDE_UPPER[k - 9];
         end
         if (bins_seen + 1 >= stop) begin
            lvl = 0;
            for (int s = 0; s < 15; s++) begin
               if (int'(band_hi[14:7]) >= LEVEL_STEPS[s]) lvl++;
            end
            target = 12'(lvl << 8);
            bar_q[band_ptr] = decay_to(bar_q[band_ptr], bar_fall, target);
            if (peak_on) peak_q[band_ptr] = decay_to(peak_q[band_ptr], 10'(peak_fall), target);
            rep.band = 7'(band_ptr);
            rep.bar  = bar_q[band_ptr];
            rep.peak = peak_q[band_ptr];
            rep.last = (k == nbands);
            band_ptr = k;
            band_hi  = '0;
            predict_band = 1'b1;
         end
      end
      if (bins_seen < FRAME_BINS) bins_seen++;
   endfunction

   task automatic deliver_bin(input logic signed [15:0] mag, input logic fs);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.bin_magnitude <= mag;
      req_ch.frame_start   <= fs;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bins_sent++;
      if (fs) frames_started++;
   endtask

   // drop valid, wait for every pending report, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (band_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic mode, input logic show, input logic [9:0] bar_f,
                                 input logic [7:0] peak_f);
      csr_wr_en   <= 1'b1;
      csr_index   <= sbpd_pkg::CSR_LONG_BAND_MODE;
      csr_wr_data <= 10'(mode);
      @(posedge clock);
      csr_index   <= sbpd_pkg::CSR_SHOW_PEAK_MARKS;
      csr_wr_data <= 10'(show);
      @(posedge clock);
      csr_index   <= sbpd_pkg::CSR_BAR_FALLOFF;
      csr_wr_data <= bar_f;
      @(posedge clock);
      csr_index   <= sbpd_pkg::CSR_PEAK_FALLOFF;
      csr_wr_data <= 10'(peak_f);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      long_mode = mode;
      peak_on   = show;
      bar_fall  = bar_f;
      peak_fall = peak_f;
      settings_used++;
   endtask

   task automatic stream_next_bin();
      logic               fs;
      logic signed [15:0] mag;
      logic [7:0]         y;
      int unsigned        r;
      band_report_type    rep;
      fs = 1'b0;
      if (frame_pos >= frame_len) begin
         fs = 1'b1;
         frame_pos = 0;
         r = $urandom_range(0, 99);
         if (r < 55) frame_len = FRAME_BINS;
         else if (r < 65) frame_len = $urandom_range(FRAME_BINS + 1, FRAME_BINS + 44);
         else frame_len = $urandom_range(1, 120);
      end else if ($urandom_range(0, 99) < 4) begin
         // stray frame start inside a frame
         fs = 1'b1;
         frame_pos = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
         mag = 16'($urandom);
      end else if (r < 25) begin
         mag = 16'sh8000 | 16'($urandom_range(0, 32767));
      end else if (r < 33) begin
         mag = '0;
      end else begin
         y = 8'($urandom_range(0, 255));
         mag = {1'b0, y, 7'($urandom_range(0, 127))};
      end
      deliver_bin(mag, fs);
      frame_pos++;
      if (predict_band(mag, fs, rep)) band_reports.push_back(rep);
   endtask

   // result side: random back-pressure and in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (band_reports.size() == 0) begin
               $error("band report with nothing pending: band_index %0d", rsp_ch.band_index);
               mismatches++;
            end else begin
               want = band_reports.pop_front();
               if (rsp_ch.band_index !== want.band) begin
                  $error("band_index: expected %0d, got %0d", want.band, rsp_ch.band_index);
                  mismatches++;
               end
               if (rsp_ch.bar_level !== want.bar) begin
                  $error("bar_level: expected %0d, got %0d", want.bar, rsp_ch.bar_level);
                  mismatches++;
               end
               if (rsp_ch.peak_level !== want.peak) begin
                  $error("peak_level: expected %0d, got %0d", want.peak, rsp_ch.peak_level);
                  mismatches++;
               end
               if (rsp_ch.last_band !== want.last) begin
                  $error("last_band: expected %0d, got %0d", want.last, rsp_ch.last_band);
                  mismatches++;
               end
               reports_checked++;
               if (want.last) frame_closes++;
            end
         end
         if (stall_left == 0) stall_left = pick_gap();
         else stall_left--;
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   initial begin
      band_report_type rep;
      logic            emitted;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = sbpd_pkg::CSR_LONG_BAND_MODE;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.bin_magnitude = '0;
      req_ch.frame_start   = 1'b0;
      calm                 = 1'b0;
      bins_sent            = 0;
      frames_started       = 0;
      settings_used        = 1;
      frame_pos            = 0;
      frame_len            = 0;
      long_mode            = 1'b0;
      peak_on              = 1'b1;
      bar_fall             = 10'd563;
      peak_fall            = 8'd51;
      bins_seen            = 0;
      band_ptr             = 0;
      band_hi              = '0;
      for (int i = 0; i < NARROW_COUNT; i++) begin
         bar_q[i]  = '0;
         peak_q[i] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BINS[i]) begin
         deliver_bin(DIRECTED_BINS[i].mag, DIRECTED_BINS[i].fs);
         emitted = predict_band(DIRECTED_BINS[i].mag, DIRECTED_BINS[i].fs, rep);
         if (DIRECTED_BINS[i].typed) begin
            if (DIRECTED_BINS[i].emits) band_reports.push_back(DIRECTED_BINS[i].rep);
         end else if (emitted) begin
            band_reports.push_back(rep);
         end
      end
      settle();

      // phases run on from one another, so settings also change mid-frame
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       apply_settings(1'b1, 1'b1, 10'd563, 8'd51);
            1:       apply_settings(1'b1, 1'b0, 10'd0, 8'd255);
            2:       apply_settings(1'b0, 1'b1, 10'd1023, 8'd0);
            3:       apply_settings(1'b1, 1'b1, 10'd1023, 8'd255);
            4:       apply_settings(1'b0, 1'b0, 10'd0, 8'd0);
            default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
         endcase
         calm = (phase % 3 == 2);
         repeat ($urandom_range(50, 70)) stream_next_bin();
         settle();
      end

      $display("Streamed %0d bins with %0d frame starts under %0d register settings.",
               bins_sent, frames_started, settings_used);
      $display("Compared %0d band reports, %0d of them final bands; %0d mismatches.",
               reports_checked, frame_closes, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d band reports pending.", band_reports.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
